FILE: hdl/sidelink_sensing_resource_select_defines.svh
// Assertion macros used by the checker of the sidelink resource selector.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SIDELINK_SENSING_RESOURCE_SELECT_DEFINES_SVH
`define SIDELINK_SENSING_RESOURCE_SELECT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SSRS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define SSRS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ssrs_pkg.sv
// Types and constants of the sidelink sensing resource selector.
// Used by the entry cells, the top level and the checker; depends on nothing.
`default_nettype none

package ssrs_pkg;

  localparam int RSRP_OFFSET = 640;
  localparam int THRESH_STEP = 12;
  localparam int THRESH_MAX  = 1023;

  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_FULL     = 3'd1,
    ST_GRANT    = 3'd2,
    ST_FALLBACK = 3'd3,
    ST_BADWIN   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_T1     = 3'd0,
    CFG_T2     = 3'd1,
    CFG_PERIOD = 3'd2,
    CFG_SUBCH  = 3'd3,
    CFG_BASE   = 3'd4
  } cfg_index_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SMATCH, S_SPLACE, S_PRUNE, S_RES, S_RES_WAIT, S_WRES, S_WRES_WAIT,
    S_HCLR, S_PK_CLR, S_PEAK, S_KM, S_KM_WR, S_PS_RD, S_PS_CHK, S_SEL,
    S_SEL_WAIT, S_SC_RD, S_SC_CHK, S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] slot;
    logic [9:0]  residue;
    logic [4:0]  sub;
    logic [9:0]  rsrp;
  } payload_t;

  typedef struct packed {
    logic     valid;
    payload_t pl;
  } entry_t;

  typedef struct packed {
    logic        shift;
    logic        prune;
    logic [31:0] now;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/sidelink_sensing_resource_select.sv
// Sidelink sensing-based resource selector: a ring of entry cells, a serial
// remainder unit and a per-resource pass memory. Uses ssrs_pkg, ssrs_cell and ssrs_div.
`default_nettype none

// A command is taken when start is high and busy is low, and busy stays high
// until its single result has been shown for one cycle on out_strobe; results
// cannot be held off, so sample them in that cycle. The sensed reservations
// circulate through a ring of SENSE_ENTRIES cells past one compare point: a
// sense command turns the ring once to find its key and, if none, once more
// to place it. A select command prunes stale entries, takes each entry's slot
// residue by the period in the remainder unit, turns the ring once per window
// slot for the peak of each subchannel and updates the pass memory, runs the
// threshold passes, draws the random pick with the remainder unit and scans
// resources up to the grant. Configuration writes are always ready and must
// be issued only while busy is low.

module sidelink_sensing_resource_select
  import ssrs_pkg::*;
#(
  parameter int SENSE_ENTRIES    = 64,
  parameter int MAX_SUBCHANNELS  = 32,
  parameter int MAX_WINDOW       = 128,
  parameter int THRESHOLD_PASSES = 40
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire                in_cmd,
  input  wire         [31:0] in_slot_number,
  input  wire         [4:0]  in_subchannel,
  input  wire  signed [10:0] in_rsrp_level,
  input  wire         [15:0] in_random_value,
  output logic               out_strobe,
  output logic        [2:0]  out_status,
  output logic        [31:0] out_grant_slot,
  output logic        [4:0]  out_grant_subchannel,
  output logic        [12:0] out_candidate_count,
  output logic signed [10:0] out_final_threshold,
  output logic        [15:0] out_reselection_total,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire         [2:0]  cfg_index,
  input  wire         [10:0] cfg_data
);

  localparam int EW     = $clog2(SENSE_ENTRIES);
  localparam int CW     = (MAX_SUBCHANNELS > 1) ? $clog2(MAX_SUBCHANNELS) : 1;
  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PW     = (THRESHOLD_PASSES > 1) ? $clog2(THRESHOLD_PASSES) : 1;
  localparam int KW     = $clog2(THRESHOLD_PASSES + 1);
  localparam int KDEPTH = MAX_WINDOW * (1 << CW);

  function automatic logic [6:0] k_step(input logic has, input logic [9:0] code,
                                        input logic signed [10:0] base);
    logic signed [12:0] d;
    logic [12:0]        dp;
    logic [8:0]         x;
    logic [17:0]        prod;
    logic [6:0]         k;
    d  = $signed({3'b000, code}) - 13'sd640 - 13'(base);
    dp = 13'(d + 13'sd11);
    x  = dp[10:2];
    prod = 18'(x) * 18'd171;
    if (!has || (d <= 13'sd0)) begin
      k = '0;
    end else begin
      k = prod[15:9];
    end
    return k;
  endfunction

  // configuration
  logic [6:0]         t1_r;
  logic [7:0]         t2_r;
  logic [9:0]         per_r;
  logic [5:0]         sc_r;
  logic signed [10:0] base_r;

  state_t state_r, state_nxt;

  logic [31:0] q_slot_r;
  logic [4:0]  q_sub_r;
  logic [9:0]  q_code_r;
  logic [15:0] q_rnd_r;
  logic [15:0] sel_cnt_r;

  logic [EW-1:0] ent_r;
  logic [AW-1:0] w_r;
  logic [CW-1:0] c_r;
  logic [PW-1:0] p_r;
  logic          matched_r;
  logic          placed_r;
  logic [9:0]    wres_r;
  logic [KW-1:0] kmin_r;
  logic [12:0]   cum_r;
  logic signed [10:0] thr_r;
  logic [12:0]   cnt_fin_r;
  logic [PW-1:0] pf_r;
  logic signed [10:0] used_r;
  logic          fb_r;
  logic [12:0]   kpick_r;
  logic [12:0]   seen_r;

  status_t            res_status_r;
  logic [31:0]        res_slot_r;
  logic [4:0]         res_sub_r;
  logic [12:0]        res_cnt_r;
  logic signed [10:0] res_thr_r;

  logic [9:0] pk_code_r [MAX_SUBCHANNELS];
  logic       pk_has_r  [MAX_SUBCHANNELS];

  logic [12:0]   hist_mem [THRESHOLD_PASSES];
  logic [12:0]   hist_q;
  logic [PW-1:0] hist_raddr;
  logic [KW-1:0] kmem [KDEPTH];
  logic [KW-1:0] km_q;

  entry_t     cell_q [SENSE_ENTRIES];
  entry_t     head;
  entry_t     ring_fb;
  cell_ctrl_t cell_ctrl;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [12:0] div_divisor;
  logic        div_done;
  logic [12:0] div_rem;

  // derived values
  logic [8:0]  nw9;
  logic [5:0]  sc_eff;
  logic        bad_win;
  logic [14:0] total15;
  logic [12:0] total;
  logic [31:0] start_slot;
  logic        ent_last;
  logic        c_last;
  logic        w_last;
  logic        p_last;
  logic        per_nz;
  logic        hit;
  logic        res_div;
  logic [6:0]  kraw;
  logic [KW-1:0] kcap;
  logic [13:0] cum_n;
  logic [16:0] cum5;
  logic        stop;
  logic [12:0] cand_total;
  logic        cand;
  logic [11:0] thr_up;
  logic [11:0] rsrp_ofs;
  logic [9:0]  in_code;
  logic [CW-1:0] head_idx;
  logic        head_in_range;

  assign per_nz   = (per_r != 10'd0);
  assign nw9      = {1'b0, t2_r} - {2'b00, t1_r} + 9'd1;
  assign sc_eff   = (sc_r > 6'(MAX_SUBCHANNELS)) ? 6'(MAX_SUBCHANNELS) : sc_r;
  assign bad_win  = (t2_r <= {1'b0, t1_r}) || (sc_r == 6'd0) ||
                    (nw9 > 9'(MAX_WINDOW));
  assign total15  = 15'(nw9) * 15'(sc_eff);
  assign total    = total15[12:0];
  assign start_slot = q_slot_r + {25'd0, t1_r};
  assign ent_last = (ent_r == EW'(SENSE_ENTRIES - 1));
  assign c_last   = (c_r == CW'(sc_eff - 6'd1));
  assign w_last   = (w_r == AW'(nw9 - 9'd1));
  assign p_last   = (p_r == PW'(THRESHOLD_PASSES - 1));

  assign head     = cell_q[SENSE_ENTRIES-1];
  assign hit      = head.valid && (head.pl.slot == q_slot_r) && (head.pl.sub == q_sub_r);
  assign res_div  = head.valid && per_nz;
  assign head_idx = head.pl.sub[CW-1:0];
  assign head_in_range = ({1'b0, head.pl.sub} < 6'(MAX_SUBCHANNELS));

  assign kraw = k_step(pk_has_r[c_r], pk_code_r[c_r], base_r);
  assign kcap = ({1'b0, kraw} >= 8'(THRESHOLD_PASSES)) ? KW'(THRESHOLD_PASSES) : KW'(kraw);

  assign cum_n = {1'b0, cum_r} + {1'b0, hist_q};
  assign cum5  = 17'(cum_n) * 17'd5;
  assign stop  = (cum5 >= 17'(total)) || p_last;
  assign cand_total = (cnt_fin_r == 13'd0) ? total : cnt_fin_r;
  assign cand  = fb_r || (km_q <= KW'(pf_r));
  assign thr_up = 12'(thr_r) + 12'sd12;

  assign rsrp_ofs = 12'(in_rsrp_level) + 12'd640;
  assign in_code  = (in_rsrp_level < -11'sd640) ? 10'd0 :
                    (in_rsrp_level > 11'sd0) ? 10'd640 : rsrp_ofs[9:0];

  // entry ring
  for (genvar g = 0; g < SENSE_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      ssrs_cell u_cell (.clk(clk), .rst_n(rst_n), .ctrl(cell_ctrl), .d(ring_fb),
                        .q(cell_q[g]));
    end else begin : g_body
      ssrs_cell u_cell (.clk(clk), .rst_n(rst_n), .ctrl(cell_ctrl), .d(cell_q[g-1]),
                        .q(cell_q[g]));
    end
  end

  ssrs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .rem(div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (start) state_nxt = in_cmd ? S_PRUNE : S_SMATCH;
      S_SMATCH:    if (ent_last) state_nxt = (matched_r || hit) ? S_DONE : S_SPLACE;
      S_SPLACE:    if (ent_last) state_nxt = S_DONE;
      S_PRUNE:     state_nxt = bad_win ? S_DONE : S_RES;
      S_RES: begin
        if (res_div) state_nxt = S_RES_WAIT;
        else if (ent_last) state_nxt = S_WRES;
      end
      S_RES_WAIT:  if (div_done) state_nxt = ent_last ? S_WRES : S_RES;
      S_WRES:      state_nxt = per_nz ? S_WRES_WAIT : S_HCLR;
      S_WRES_WAIT: if (div_done) state_nxt = S_HCLR;
      S_HCLR:      if (p_last) state_nxt = S_PK_CLR;
      S_PK_CLR:    state_nxt = S_PEAK;
      S_PEAK:      if (ent_last) state_nxt = S_KM;
      S_KM:        state_nxt = S_KM_WR;
      S_KM_WR: begin
        if (!c_last) state_nxt = S_KM;
        else state_nxt = w_last ? S_PS_RD : S_PK_CLR;
      end
      S_PS_RD:     state_nxt = S_PS_CHK;
      S_PS_CHK:    state_nxt = stop ? S_SEL : S_PS_RD;
      S_SEL:       state_nxt = S_SEL_WAIT;
      S_SEL_WAIT:  if (div_done) state_nxt = S_SC_RD;
      S_SC_RD:     state_nxt = S_SC_CHK;
      S_SC_CHK: begin
        if ((cand && (seen_r == kpick_r)) || (c_last && w_last)) state_nxt = S_DONE;
        else state_nxt = S_SC_RD;
      end
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy       = (state_r != S_IDLE);
    out_strobe = (state_r == S_DONE);
    div_start  = ((state_r == S_RES) && res_div) || ((state_r == S_WRES) && per_nz) ||
                 (state_r == S_SEL);
    cell_ctrl.prune = (state_r == S_PRUNE);
    cell_ctrl.now   = q_slot_r;
    cell_ctrl.shift = (state_r == S_SMATCH) || (state_r == S_SPLACE) ||
                      (state_r == S_PEAK) || ((state_r == S_RES) && !res_div) ||
                      ((state_r == S_RES_WAIT) && div_done);
    div_dividend = {16'd0, q_rnd_r};
    div_divisor  = {3'd0, per_r};
    case (state_r)
      S_RES:   div_dividend = head.pl.slot;
      S_WRES:  div_dividend = start_slot;
      S_SEL:   div_divisor  = cand_total;
      default: div_dividend = {16'd0, q_rnd_r};
    endcase
    hist_raddr = p_r;
    if ((state_r == S_KM) && (kcap < KW'(THRESHOLD_PASSES))) begin
      hist_raddr = kcap[PW-1:0];
    end
  end

  // entry written back into the ring head
  always_comb begin
    ring_fb = head;
    case (state_r)
      S_SMATCH: if (hit && (q_code_r > head.pl.rsrp)) ring_fb.pl.rsrp = q_code_r;
      S_SPLACE: begin
        if (!placed_r && !head.valid) begin
          ring_fb = '{valid: 1'b1,
                      pl: '{slot: q_slot_r, residue: 10'd0, sub: q_sub_r, rsrp: q_code_r}};
        end
      end
      S_RES:      ring_fb.pl.residue = 10'd0;
      S_RES_WAIT: ring_fb.pl.residue = div_rem[9:0];
      default:    ring_fb = head;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      sel_cnt_r <= '0;
      t1_r      <= 7'd2;
      t2_r      <= 8'd100;
      per_r     <= 10'd100;
      sc_r      <= 6'd10;
      base_r    <= -11'sd440;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_PRUNE) sel_cnt_r <= sel_cnt_r + 16'd1;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_T1:     t1_r   <= cfg_data[6:0];
          CFG_T2:     t2_r   <= cfg_data[7:0];
          CFG_PERIOD: per_r  <= cfg_data[9:0];
          CFG_SUBCH:  sc_r   <= cfg_data[5:0];
          CFG_BASE:   base_r <= $signed(cfg_data);
          default:    ;
        endcase
      end
    end
  end

  assign cfg_ready = 1'b1;

  // datapath
  always_ff @(posedge clk) begin
    if (cell_ctrl.shift) ent_r <= ent_last ? '0 : ent_r + EW'(1);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          q_slot_r  <= in_slot_number;
          q_sub_r   <= in_subchannel;
          q_code_r  <= in_code;
          q_rnd_r   <= in_random_value;
          ent_r     <= '0;
          matched_r <= 1'b0;
          placed_r  <= 1'b0;
        end
      end
      S_SMATCH: begin
        if (hit) matched_r <= 1'b1;
        if (ent_last) begin
          res_status_r <= ST_STORED;
          res_slot_r   <= '0;
          res_sub_r    <= '0;
          res_cnt_r    <= '0;
          res_thr_r    <= '0;
        end
      end
      S_SPLACE: begin
        if (!head.valid) placed_r <= 1'b1;
        if (ent_last) begin
          res_status_r <= (placed_r || !head.valid) ? ST_STORED : ST_FULL;
        end
      end
      S_PRUNE: begin
        res_status_r <= ST_BADWIN;
        res_slot_r   <= '0;
        res_sub_r    <= '0;
        res_cnt_r    <= '0;
        res_thr_r    <= '0;
      end
      S_WRES: begin
        w_r    <= '0;
        c_r    <= '0;
        p_r    <= '0;
        wres_r <= '0;
      end
      S_WRES_WAIT: if (div_done) wres_r <= div_rem[9:0];
      S_HCLR:      p_r <= p_r + PW'(1);
      S_PK_CLR: begin
        for (int i = 0; i < MAX_SUBCHANNELS; i++) pk_has_r[i] <= 1'b0;
        c_r <= '0;
      end
      S_PEAK: begin
        if (head.valid && head_in_range && (!per_nz || (head.pl.residue == wres_r))) begin
          if (!pk_has_r[head_idx] || (head.pl.rsrp > pk_code_r[head_idx])) begin
            pk_has_r[head_idx]  <= 1'b1;
            pk_code_r[head_idx] <= head.pl.rsrp;
          end
        end
      end
      S_KM: kmin_r <= kcap;
      S_KM_WR: begin
        if (c_last) begin
          c_r <= '0;
          w_r <= w_r + AW'(1);
          if (per_nz) wres_r <= ((wres_r + 10'd1) == per_r) ? 10'd0 : wres_r + 10'd1;
          if (w_last) begin
            p_r   <= '0;
            cum_r <= '0;
            thr_r <= base_r;
          end
        end else begin
          c_r <= c_r + CW'(1);
        end
      end
      S_PS_CHK: begin
        if (stop) begin
          cnt_fin_r <= cum_n[12:0];
          pf_r      <= p_r;
          used_r    <= thr_r;
        end else begin
          p_r   <= p_r + PW'(1);
          cum_r <= cum_n[12:0];
          thr_r <= ($signed(thr_up) > 12'sd1023) ? 11'sd1023 : thr_up[10:0];
        end
      end
      S_SEL: fb_r <= (cnt_fin_r == 13'd0);
      S_SEL_WAIT: begin
        if (div_done) begin
          kpick_r <= div_rem;
          w_r     <= '0;
          c_r     <= '0;
          seen_r  <= '0;
        end
      end
      S_SC_CHK: begin
        if ((cand && (seen_r == kpick_r)) || (c_last && w_last)) begin
          res_status_r <= fb_r ? ST_FALLBACK : ST_GRANT;
          res_cnt_r    <= cand_total;
          res_thr_r    <= used_r;
          res_slot_r   <= '0;
          res_sub_r    <= '0;
          if (cand && (seen_r == kpick_r)) begin
            res_slot_r <= start_slot + 32'(w_r);
            res_sub_r  <= 5'(c_r);
          end
        end else begin
          if (cand) seen_r <= seen_r + 13'd1;
          if (c_last) begin
            c_r <= '0;
            w_r <= w_r + AW'(1);
          end else begin
            c_r <= c_r + CW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // pass histogram memory
  always_ff @(posedge clk) begin
    if (state_r == S_HCLR) begin
      hist_mem[p_r] <= '0;
    end else if ((state_r == S_KM_WR) && (kmin_r < KW'(THRESHOLD_PASSES))) begin
      hist_mem[kmin_r[PW-1:0]] <= hist_q + 13'd1;
    end
    hist_q <= hist_mem[hist_raddr];
  end

  // first-pass index of each window resource
  always_ff @(posedge clk) begin
    if (state_r == S_KM) kmem[{w_r, c_r}] <= kcap;
    km_q <= kmem[{w_r, c_r}];
  end

  assign out_status            = res_status_r;
  assign out_grant_slot        = res_slot_r;
  assign out_grant_subchannel  = res_sub_r;
  assign out_candidate_count   = res_cnt_r;
  assign out_final_threshold   = res_thr_r;
  assign out_reselection_total = sel_cnt_r;

endmodule

`default_nettype wire

FILE: hdl/ssrs_cell.sv
// One entry cell of the reservation ring: holds one sensed reservation.
// Takes its neighbor's entry on a shift and drops a stale entry on a prune.
`default_nettype none

module ssrs_cell
  import ssrs_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  cell_ctrl_t ctrl,
  input  entry_t     d,
  output entry_t     q
);

  logic     valid_r;
  payload_t pl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.shift) begin
      valid_r <= d.valid;
    end else if (ctrl.prune && valid_r && (pl_r.slot < ctrl.now)) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pl_r <= d.pl;
    end
  end

  assign q = '{valid: valid_r, pl: pl_r};

endmodule

`default_nettype wire

FILE: hdl/ssrs_div.sv
// Bit-serial remainder unit: 32-bit dividend, 13-bit nonzero divisor.
// One quotient bit per cycle; done pulses when the remainder is ready.
`default_nettype none

module ssrs_div (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire  [31:0] dividend,
  input  wire  [12:0] divisor,
  output logic        done,
  output logic [12:0] rem
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] quo_r;
  logic [12:0] rem_r;
  logic [12:0] dsr_r;
  logic [13:0] rem_sh;
  logic [13:0] rem_sub;

  assign rem_sh  = {rem_r, quo_r[31]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == 5'd31)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      quo_r <= {quo_r[30:0], 1'b0};
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_r <= rem_sub[12:0];
      end else begin
        rem_r <= rem_sh[12:0];
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: hdl/ssrs_checker.sv
// Port-level checker for the sidelink resource selector, bound to the top level.
// Depends on ssrs_pkg and the assertion macros header.
`default_nettype none
`include "sidelink_sensing_resource_select_defines.svh"

module ssrs_checker
  import ssrs_pkg::*;
(
  input wire               clk,
  input wire               rst_n,
  input wire               start,
  input wire               busy,
  input wire               in_cmd,
  input wire        [31:0] in_slot_number,
  input wire        [4:0]  in_subchannel,
  input wire signed [10:0] in_rsrp_level,
  input wire        [15:0] in_random_value,
  input wire               out_strobe,
  input wire        [2:0]  out_status,
  input wire        [31:0] out_grant_slot,
  input wire        [4:0]  out_grant_subchannel,
  input wire        [12:0] out_candidate_count,
  input wire signed [10:0] out_final_threshold,
  input wire        [15:0] out_reselection_total,
  input wire               cfg_valid,
  input wire               cfg_ready,
  input wire        [2:0]  cfg_index,
  input wire        [10:0] cfg_data
);

  `SSRS_ASSERT_IMP(a_strobe_busy, out_strobe, busy, "result shown while idle")
  `SSRS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `SSRS_ASSERT_NXT(a_one_result, out_strobe, !out_strobe, "more than one result per word")
  `SSRS_ASSERT_IMP(a_badwin_zero, out_strobe && (out_status == ST_BADWIN), (out_candidate_count == 13'd0) && (out_grant_slot == 32'd0), "bad window result not cleared")
  `SSRS_ASSERT_IMP(a_grant_count, out_strobe && ((out_status == ST_GRANT) || (out_status == ST_FALLBACK)), out_candidate_count != 13'd0, "grant with empty candidate set")

endmodule

bind sidelink_sensing_resource_select ssrs_checker u_ssrs_checker (.*);

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for sidelink_sensing_resource_select: directed and random sense and
// select words, checked against a predictor of the reservation table and the resource scan.
// Depends on ssrs_pkg and the RTL of the block; reads no files.
`default_nettype none

module tb_top;
  import ssrs_pkg::*;

  localparam bit CMD_SENSE      = 1'b0;
  localparam bit CMD_SELECT     = 1'b1;
  localparam int TABLE_DEPTH    = 64;
  localparam int SUBCH_LIMIT    = 32;
  localparam int WINDOW_LIMIT   = 128;
  localparam int PASS_LIMIT     = 40;
  localparam int NO_PEAK        = -4096;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] slot;
    logic [4:0]  sub;
    logic [12:0] count;
    logic [10:0] thresh;
    logic [15:0] total;
  } grant_word_t;

  class selection_scoreboard;
    bit          valid[TABLE_DEPTH];
    bit [31:0]   res_slot[TABLE_DEPTH];
    bit [4:0]    res_sub[TABLE_DEPTH];
    int          res_code[TABLE_DEPTH];
    bit [15:0]   select_total;
    bit [31:0]   t1, t2, period, subch;
    int          base;
    int          peak[WINDOW_LIMIT * SUBCH_LIMIT];
    grant_word_t grant_q[$];
    int          errors;
    int          status_seen[8];

    function new();
      foreach (valid[i]) valid[i] = 1'b0;
      select_total = 0;
      t1 = 2;
      t2 = 100;
      period = 100;
      subch = 10;
      base = -440;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(cfg_index_t idx, bit [10:0] data);
      case (idx)
        CFG_T1:     t1 = data[6:0];
        CFG_T2:     t2 = data[7:0];
        CFG_PERIOD: period = data[9:0];
        CFG_SUBCH:  subch = data[5:0];
        CFG_BASE:   base = $signed(data);
        default: ;
      endcase
    endfunction

    function void push_word(status_t st, bit [31:0] slot, int sub, int cnt, int thr);
      grant_word_t w;
      w.status = st;
      w.slot = slot;
      w.sub = 5'(sub);
      w.count = 13'(cnt);
      w.thresh = 11'(thr);
      w.total = select_total;
      grant_q.push_back(w);
    endfunction

    function void record_sense(bit [31:0] slot, bit [4:0] sub, int rsrp);
      int code;
      if (rsrp < -640) rsrp = -640;
      if (rsrp > 0) rsrp = 0;
      code = rsrp + 640;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (valid[i] && res_slot[i] == slot && res_sub[i] == sub) begin
          if (code > res_code[i]) res_code[i] = code;
          push_word(ST_STORED, 0, 0, 0, 0);
          return;
        end
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (!valid[i]) begin
          valid[i] = 1'b1;
          res_slot[i] = slot;
          res_sub[i] = sub;
          res_code[i] = code;
          push_word(ST_STORED, 0, 0, 0, 0);
          return;
        end
      end
      push_word(ST_FULL, 0, 0, 0, 0);
    endfunction

    function void select_resource(bit [31:0] now, bit [15:0] rnd);
      bit [31:0] sc, nw, total, start, s, k;
      int thr, used, count, seen, best;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (valid[i] && res_slot[i] < now) valid[i] = 1'b0;
      select_total = select_total + 16'd1;
      sc = (subch > SUBCH_LIMIT) ? SUBCH_LIMIT : subch;
      if (t2 <= t1 || sc == 0 || t2 - t1 + 1 > WINDOW_LIMIT) begin
        push_word(ST_BADWIN, 0, 0, 0, 0);
        return;
      end
      nw = t2 - t1 + 1;
      total = nw * sc;
      start = now + t1;
      for (int w = 0; w < nw; w++) begin
        s = start + w;
        for (int c = 0; c < sc; c++) begin
          best = NO_PEAK;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (valid[i] && res_sub[i] == c &&
                (period == 0 || res_slot[i] % period == s % period))
              if (res_code[i] - 640 > best) best = res_code[i] - 640;
          peak[w * sc + c] = best;
        end
      end
      thr = base;
      used = thr;
      count = 0;
      for (int p = 0; p < PASS_LIMIT; p++) begin
        used = thr;
        count = 0;
        for (int w = 0; w < total; w++)
          if (!(peak[w] > used)) count++;
        if (count * 5 >= total) break;
        thr = (thr + 12 > 1023) ? 1023 : thr + 12;
      end
      if (count == 0) begin
        k = rnd % total;
        push_word(ST_FALLBACK, start + k / sc, k % sc, total, used);
        return;
      end
      k = rnd % count;
      seen = 0;
      for (int w = 0; w < total; w++) begin
        if (!(peak[w] > used)) begin
          if (seen == k) begin
            push_word(ST_GRANT, start + w / sc, w % sc, count, used);
            return;
          end
          seen++;
        end
      end
      push_word(ST_GRANT, 0, 0, count, used);
    endfunction

    function void note_input(bit cmd, bit [31:0] slot, bit [4:0] sub,
                             logic signed [10:0] rsrp, bit [15:0] rnd);
      if (cmd == CMD_SENSE) record_sense(slot, sub, rsrp);
      else select_resource(slot, rnd);
    endfunction

    function void compare_field(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(grant_word_t got);
      grant_word_t exp_w;
      if (grant_q.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, status %0d", $time, got.status);
        return;
      end
      exp_w = grant_q.pop_front();
      status_seen[exp_w.status]++;
      compare_field("status", exp_w.status, got.status);
      compare_field("grant_slot", exp_w.slot, got.slot);
      compare_field("grant_subchannel", exp_w.sub, got.sub);
      compare_field("candidate_count", exp_w.count, got.count);
      compare_field("final_threshold", $signed(exp_w.thresh), $signed(got.thresh));
      compare_field("reselection_total", exp_w.total, got.total);
    endfunction

    function int pending();
      return grant_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_cmd;
  logic        [31:0] in_slot_number;
  logic        [4:0]  in_subchannel;
  logic signed [10:0] in_rsrp_level;
  logic        [15:0] in_random_value;
  logic               out_strobe;
  logic        [2:0]  out_status;
  logic        [31:0] out_grant_slot;
  logic        [4:0]  out_grant_subchannel;
  logic        [12:0] out_candidate_count;
  logic signed [10:0] out_final_threshold;
  logic        [15:0] out_reselection_total;
  logic               cfg_valid;
  logic               cfg_ready;
  logic        [2:0]  cfg_index;
  logic        [10:0] cfg_data;

  selection_scoreboard sb;
  int idle_cycles;
  int items_sent;

  sidelink_sensing_resource_select DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_slot_number(in_slot_number), .in_subchannel(in_subchannel),
    .in_rsrp_level(in_rsrp_level), .in_random_value(in_random_value),
    .out_strobe(out_strobe), .out_status(out_status), .out_grant_slot(out_grant_slot),
    .out_grant_subchannel(out_grant_subchannel), .out_candidate_count(out_candidate_count),
    .out_final_threshold(out_final_threshold), .out_reselection_total(out_reselection_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result({out_status, out_grant_slot, out_grant_subchannel,
                       out_candidate_count, out_final_threshold, out_reselection_total});
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sidelink_sensing_resource_select verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(bit cmd, bit [31:0] slot, bit [4:0] sub, bit [10:0] rsrp,
                           bit [15:0] rnd, int idle_pct);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_cmd <= cmd;
    in_slot_number <= slot;
    in_subchannel <= sub;
    in_rsrp_level <= rsrp;
    in_random_value <= rnd;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_input(cmd, slot, sub, rsrp, rnd);
    items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setup(int t1, int t2, int per, int sc, int base);
    int vals[5];
    vals = '{t1, t2, per, sc, base};
    settle();
    for (int i = 0; i < 5; i++) begin
      cfg_index <= 3'(i);
      cfg_data <= 11'(vals[i]);
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(cfg_index_t'(i), 11'(vals[i]));
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit [31:0] now, slot, last_slot;
    bit [4:0]  sub, last_sub;
    bit [10:0] rsrp;
    bit        have_key;
    int        t1, t2, per, sc, base, idle_pct, n_items, sub_top;
    sb = new();
    idle_cycles = 0;
    items_sent = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_SENSE;
    in_slot_number = '0;
    in_subchannel = '0;
    in_rsrp_level = '0;
    in_random_value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_T1;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setup: empty table, key updates, RSRP saturation, wrap-around window.
    send_item(CMD_SELECT, 1000, 0, 0, 0, 0);
    send_item(CMD_SENSE, 1005, 0, 0, 0, 0);
    send_item(CMD_SENSE, 1005, 0, -11'sd640, 0, 0);
    send_item(CMD_SENSE, 1006, 31, 11'h400, 0, 0);
    send_item(CMD_SENSE, 1007, 9, 11'h3FF, 0, 0);
    send_item(CMD_SELECT, 1000, 0, 0, 16'hFFFF, 0);
    send_item(CMD_SENSE, 0, 1, -11'sd300, 0, 0);
    send_item(CMD_SENSE, 32'hFFFF_FFFF, 2, -11'sd200, 0, 0);
    send_item(CMD_SELECT, 32'hFFFF_FFF8, 0, 0, 12345, 0);
    // Period zero blocks a whole subchannel: fallback, then passes exhausted.
    apply_setup(0, 1, 0, 1, -640);
    send_item(CMD_SENSE, 10, 0, 0, 0, 0);
    send_item(CMD_SELECT, 5, 0, 0, 1, 0);
    apply_setup(0, 1, 0, 6, -640);
    for (int i = 1; i < 5; i++) send_item(CMD_SENSE, 10, 5'(i), 0, 0, 0);
    send_item(CMD_SELECT, 5, 0, 0, 7, 0);
    apply_setup(0, 1, 0, 1, -100);
    send_item(CMD_SELECT, 6, 0, 0, 3, 0);
    // Bad windows: empty, no subchannels, too long.
    apply_setup(5, 5, 100, 10, -440);
    send_item(CMD_SELECT, 7, 0, 0, 0, 0);
    apply_setup(0, 20, 100, 0, -440);
    send_item(CMD_SELECT, 8, 0, 0, 0, 0);
    apply_setup(0, 128, 1023, 4, -440);
    send_item(CMD_SELECT, 9, 0, 0, 0, 0);

    for (int b = 0; b < 9; b++) begin
      t1 = $urandom_range(0, 9);
      t2 = t1 + $urandom_range(1, 30);
      case ($urandom_range(3))
        0: per = 0;
        1: per = 1023;
        2: per = $urandom_range(1, 200);
        default: per = 100;
      endcase
      sc = $urandom_range(1, 8);
      base = -$urandom_range(0, 640);
      if (b == 0) base = -640;
      if (b == 8) base = 0;
      if (b == 2) begin
        t1 = 0;
        t2 = 127;
        sc = 32;
      end
      if (b == 6) begin
        t1 = 127;
        t2 = 254;
        sc = 2;
      end
      if (b == 7) sc = 63;
      idle_pct = (b < 3) ? 15 : (b < 6) ? 59 : 0;
      n_items = (b == 4) ? 68 : 9;
      apply_setup(t1, t2, per, sc, base);
      now = (b == 3) ? 32'hFFFF_FFF0 - $urandom_range(0, 40) : $urandom();
      have_key = 1'b0;
      sub_top = (sc > 32) ? 31 : sc - 1;
      for (int n = 0; n < n_items; n++) begin
        if ((b == 4) ? (n >= n_items - 2) : ($urandom_range(99) < 40)) begin
          now = now + $urandom_range(0, 4);
          send_item(CMD_SELECT, now, 5'($urandom()), 11'($urandom()),
                    16'($urandom_range(0, 65535)), idle_pct);
        end else begin
          if (have_key && $urandom_range(99) < 25) begin
            slot = last_slot;
            sub = last_sub;
          end else begin
            case ($urandom_range(9))
              0: slot = now - $urandom_range(1, 50);
              1: slot = $urandom();
              default: slot = now + $urandom_range(0, (b == 4) ? 2000 : t2 + 3);
            endcase
            sub = ($urandom_range(99) < 80) ? 5'($urandom_range(0, sub_top))
                                            : 5'($urandom_range(0, 31));
          end
          rsrp = ($urandom_range(99) < 85) ? 11'(-$urandom_range(0, 640))
                                           : 11'($urandom_range(0, 2047));
          send_item(CMD_SENSE, slot, sub, rsrp, 16'($urandom()), idle_pct);
          last_slot = slot;
          last_sub = sub;
          have_key = 1'b1;
        end
      end
    end

    settle();
    repeat (50) @(posedge clk);
    $display("Run covered %0d words: %0d stored, %0d dropped on a full table,",
             items_sent, sb.status_seen[ST_STORED], sb.status_seen[ST_FULL]);
    $display("%0d grants, %0d fallback grants and %0d bad windows; %0d mismatches.",
             sb.status_seen[ST_GRANT], sb.status_seen[ST_FALLBACK],
             sb.status_seen[ST_BADWIN], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sidelink_sensing_resource_select verification clean");
    end else begin
      $display("sidelink_sensing_resource_select verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/ssrs_pkg.sv
hdl/ssrs_cell.sv
hdl/ssrs_div.sv
hdl/sidelink_sensing_resource_select.sv
hdl/ssrs_checker.sv
verif/tb_top.sv
